/* design/pops_pkg.sv */
package pops_pkg;

	localparam int unsigned ReadingW = 12;
	localparam int unsigned CellOneW = 16;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 3;

	localparam int unsigned UndervoltDelayMsDefault = 2000;
	localparam int unsigned BlinkMsDefault          = 1000;

	localparam logic [ReadingW-1:0] InputCurrentMaxRst  = 12'd950;
	localparam logic [ReadingW-1:0] PackVoltageMinRst   = 12'd1406;
	localparam logic [ReadingW-1:0] OutputVoltageMaxRst = 12'd2890;
	localparam logic [ReadingW-1:0] OutputCurrentMaxRst = 12'd1950;
	localparam logic [ReadingW-1:0] OutputVoltageMinRst = 12'd2750;
	localparam logic [ReadingW-1:0] FanOnCurrentRst     = 12'd600;
	localparam logic [CellOneW-1:0] CellOneMinRst       = 16'd710;
	localparam logic [ReadingW-1:0] CellTwoMinRst       = 12'd696;

	typedef enum logic [CfgIdxW-1:0] {
		REG_INPUT_CURRENT_MAX  = 3'd0,
		REG_PACK_VOLTAGE_MIN   = 3'd1,
		REG_OUTPUT_VOLTAGE_MAX = 3'd2,
		REG_OUTPUT_CURRENT_MAX = 3'd3,
		REG_OUTPUT_VOLTAGE_MIN = 3'd4,
		REG_FAN_ON_CURRENT     = 3'd5,
		REG_CELL_ONE_MIN       = 3'd6,
		REG_CELL_TWO_MIN       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [ReadingW-1:0] input_current;
		logic [ReadingW-1:0] output_current;
		logic [ReadingW-1:0] output_voltage;
		logic [ReadingW-1:0] pack_voltage;
		logic [ReadingW-1:0] cell_two_voltage;
		logic [TimeW-1:0]    now_ms;
	} sample_t;

	typedef struct packed {
		logic                output_enable;
		logic                fan_on;
		logic                switch_led;
		logic                cell_one_ok;
		logic                cell_two_ok;
		logic                overcurrent_fault;
		logic                undervoltage_fault;
		logic [CellOneW-1:0] cell_one_voltage;
	} result_t;

endpackage

/* design/power_output_protection_supervisor.sv */
// Power output protection supervisor.
// Sample channel (sample_valid/sample_ready/sample) carries one word of five
// 12-bit converter readings plus a millisecond time stamp. Result channel
// (result_valid/result_ready/result) returns one word per sample: output
// enable, fan, switch LED level, cell OK flags, latched faults and the
// derived first cell voltage.
// Limits are set through cfg_wr_en/cfg_index/cfg_data; the user must write them
// only while no sample is in flight, which the block does not enforce. Writes
// take effect at once; indexes map to cfg_reg_t. A sample enters the input
// register on acceptance and its result the output register once that is free.
// Throughput: one sample per cycle while the output is not stalled; the
// compare-and-latch logic between the two registers is the only stage.
// The latches, time marks and LED level advance as a sample moves into the
// output register, so results follow sample order.
// Reset clears both fault latches, both time marks, the LED level and all
// valid flags, and restores the default limits.
// While result_valid is high and result_ready low the result word holds, the
// input register keeps one more sample, sample_ready drops until output drains.
module power_output_protection_supervisor
	import pops_pkg::*;
#(
	parameter int unsigned UNDERVOLT_DELAY_MS = UndervoltDelayMsDefault,
	parameter int unsigned BLINK_MS           = BlinkMsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  sample_t             sample,
	output logic                result_valid,
	input  logic                result_ready,
	output result_t             result
);

	logic [ReadingW-1:0] input_current_max_q;
	logic [ReadingW-1:0] pack_voltage_min_q;
	logic [ReadingW-1:0] output_voltage_max_q;
	logic [ReadingW-1:0] output_current_max_q;
	logic [ReadingW-1:0] output_voltage_min_q;
	logic [ReadingW-1:0] fan_on_current_q;
	logic [CellOneW-1:0] cell_one_min_q;
	logic [ReadingW-1:0] cell_two_min_q;

	logic             overcurrent_q;
	logic             undervoltage_q;
	logic [TimeW-1:0] last_healthy_q;
	logic [TimeW-1:0] last_toggle_q;
	logic             led_q;

	logic    valid_s1;
	sample_t sample_s1;
	logic    valid_s2;
	result_t result_s2;

	logic    out_free;
	logic    advance;

	logic [CellOneW-1:0] cell_one;
	logic [TimeW-1:0]    since_toggle;
	logic [TimeW-1:0]    since_healthy;
	logic                limits_ok;
	logic                enable;
	logic                blink;
	logic                led_next;
	logic                over_next;
	logic                under_low;
	logic                under_next;
	result_t             result_next;

	assign out_free     = !valid_s2 || result_ready;
	assign advance      = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || out_free;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_current_max_q  <= InputCurrentMaxRst;
			pack_voltage_min_q   <= PackVoltageMinRst;
			output_voltage_max_q <= OutputVoltageMaxRst;
			output_current_max_q <= OutputCurrentMaxRst;
			output_voltage_min_q <= OutputVoltageMinRst;
			fan_on_current_q     <= FanOnCurrentRst;
			cell_one_min_q       <= CellOneMinRst;
			cell_two_min_q       <= CellTwoMinRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INPUT_CURRENT_MAX:  input_current_max_q  <= cfg_data[ReadingW-1:0];
				REG_PACK_VOLTAGE_MIN:   pack_voltage_min_q   <= cfg_data[ReadingW-1:0];
				REG_OUTPUT_VOLTAGE_MAX: output_voltage_max_q <= cfg_data[ReadingW-1:0];
				REG_OUTPUT_CURRENT_MAX: output_current_max_q <= cfg_data[ReadingW-1:0];
				REG_OUTPUT_VOLTAGE_MIN: output_voltage_min_q <= cfg_data[ReadingW-1:0];
				REG_FAN_ON_CURRENT:     fan_on_current_q     <= cfg_data[ReadingW-1:0];
				REG_CELL_ONE_MIN:       cell_one_min_q       <= cfg_data;
				REG_CELL_TWO_MIN:       cell_two_min_q       <= cfg_data[ReadingW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cell_one = CellOneW'({4'b0, sample_s1.pack_voltage})
			- CellOneW'({4'b0, sample_s1.cell_two_voltage});
		since_toggle  = sample_s1.now_ms - last_toggle_q;
		since_healthy = sample_s1.now_ms - last_healthy_q;

		limits_ok = (sample_s1.input_current <= input_current_max_q)
			&& (sample_s1.pack_voltage >= pack_voltage_min_q)
			&& (sample_s1.output_voltage <= output_voltage_max_q)
			&& (sample_s1.output_current <= output_current_max_q);
		// faults as they stood before this sample
		enable = limits_ok && !overcurrent_q && !undervoltage_q;

		blink    = !enable && (since_toggle > TimeW'(BLINK_MS));
		led_next = enable ? 1'b1 : (blink ? !led_q : led_q);

		over_next  = overcurrent_q || (sample_s1.output_current > output_current_max_q);
		under_low  = sample_s1.output_voltage <= output_voltage_min_q;
		under_next = undervoltage_q
			|| (under_low && (since_healthy >= TimeW'(UNDERVOLT_DELAY_MS)));

		result_next.output_enable      = enable;
		result_next.fan_on             = sample_s1.output_current >= fan_on_current_q;
		result_next.switch_led         = led_next;
		result_next.cell_one_ok        = cell_one > cell_one_min_q;
		result_next.cell_two_ok        = sample_s1.cell_two_voltage > cell_two_min_q;
		result_next.overcurrent_fault  = over_next;
		result_next.undervoltage_fault = under_next;
		result_next.cell_one_voltage   = cell_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	// advance state only as a word moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overcurrent_q  <= 1'b0;
			undervoltage_q <= 1'b0;
			last_healthy_q <= '0;
			last_toggle_q  <= '0;
			led_q          <= 1'b0;
		end else if (advance) begin
			overcurrent_q  <= over_next;
			undervoltage_q <= under_next;
			led_q          <= led_next;
			if (blink) begin
				last_toggle_q <= sample_s1.now_ms;
			end
			if (!under_low) begin
				last_healthy_q <= sample_s1.now_ms;
			end
		end
	end

`ifndef SYNTHESIS
	a_over_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overcurrent_q |=> overcurrent_q)
		else $error("overcurrent latch cleared without reset");

	a_under_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		undervoltage_q |=> undervoltage_q)
		else $error("undervoltage latch cleared without reset");

	a_enable_led: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.output_enable) |-> result.switch_led)
		else $error("switch LED not lit while output enabled");

	a_enable_no_oc: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.output_enable) |-> !result.overcurrent_fault)
		else $error("output enabled together with overcurrent fault");
`endif

endmodule
